// ----- rtl/core/itaf_pkg.sv -----
`timescale 1ns / 1ps

package itaf_pkg;

    // Fixed-length modes never emit more characters than this
    localparam int MAX_FIELD_CHARS = 16;
    localparam int RESULT_CAP      = 16;
    localparam int FIELD_CAP       = (MAX_FIELD_CHARS < RESULT_CAP) ? MAX_FIELD_CHARS
                                                                    : RESULT_CAP;

    localparam int VALUE_BITS = 32;
    localparam int DEC_DIGITS = 10;
    localparam int HEX_DIGITS = 8;
    localparam int BIN_DIGITS = 16;

    // Format modes
    localparam logic [2:0] MODE_DEC  = 3'd0;
    localparam logic [2:0] MODE_FIX  = 3'd1;
    localparam logic [2:0] MODE_SDEC = 3'd2;
    localparam logic [2:0] MODE_SFIX = 3'd3;
    localparam logic [2:0] MODE_HEX  = 3'd4;
    localparam logic [2:0] MODE_BIN  = 3'd5;

    // ASCII codes
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_A     = 7'h41;
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_MINUS = 7'h2D;

    typedef logic [DEC_DIGITS-1:0][3:0] t_bcd;
    typedef logic [HEX_DIGITS-1:0][3:0] t_hex;

endpackage

// ----- rtl/core/integer_to_ascii_formatter.sv -----
`timescale 1ns / 1ps

// Integer to ASCII formatter. One input transfer carries a 32-bit value, a
// format mode (tuser) and a text position; the block answers with one output
// transfer per character, most significant first, each tagged with its row
// and column, the final one with tlast. Decimal modes run a bit-serial
// double-dabble conversion: one bit of the value per cycle into ten BCD
// digits, so a decimal item passes through an accept step, the conversion,
// a length step and then its characters (up to 16), each sent once the
// output side can take it. Hex and binary skip the conversion. Modes 6 and 7
// produce nothing and the block is ready again on the next cycle. A new input
// is taken as soon as the last character of the previous one has entered the
// output register.
module integer_to_ascii_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // s_axis_tdata: value[31:0], field_length[36:32], text_row[38:37],
    //               start_column[42:39], zero fill [47:43]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    // s_axis_tuser: mode[2:0]
    input  logic [2:0]  s_axis_tuser,
    // m_axis_tdata: char_code[6:0], out_row[8:7], out_column[13:9], zero fill [15:14]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import itaf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [2:0]  r_mode, n_mode;
    logic [31:0] r_val, n_val;
    t_bcd        r_bcd, n_bcd;
    logic [4:0]  r_bit, n_bit;
    logic        r_neg, n_neg;
    logic [4:0]  r_flen, n_flen;
    logic [1:0]  r_row, n_row;
    logic [4:0]  r_col, n_col;
    logic        r_sign_pend, n_sign_pend;
    logic [4:0]  r_rem, n_rem;
    logic [3:0]  r_idx, n_idx;
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_out_data, n_out_data;
    logic        r_out_last, n_out_last;

    // input fields
    logic [31:0] w_value;
    logic [4:0]  w_flen;
    logic [1:0]  w_row;
    logic [3:0]  w_scol;
    logic        w_accept;

    assign w_value  = s_axis_tdata[31:0];
    assign w_flen   = s_axis_tdata[36:32];
    assign w_row    = s_axis_tdata[38:37];
    assign w_scol   = s_axis_tdata[42:39];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // double-dabble correction: add 3 to every digit of 5 or more
    t_bcd w_bcd_adj;
    always_comb begin
        for (int k = 0; k < DEC_DIGITS; k++) begin
            w_bcd_adj[k] = (r_bcd[k] >= 4'd5) ? r_bcd[k] + 4'd3 : r_bcd[k];
        end
    end

    // significant decimal digits, at least one
    logic [4:0] w_sig_len;
    always_comb begin
        w_sig_len = 5'd1;
        for (int k = 0; k < DEC_DIGITS; k++) begin
            if (r_bcd[k] != 4'd0) w_sig_len = 5'(k + 1);
        end
    end

    // character at the current digit index
    t_hex       w_hex;
    logic [15:0] w_low16;
    logic [3:0] w_nib;
    logic [3:0] w_dec;
    logic [6:0] w_digit_ch;
    assign w_hex   = r_val;
    assign w_low16 = r_val[15:0];
    assign w_nib   = w_hex[r_idx[2:0]];
    assign w_dec   = (r_idx < 4'(DEC_DIGITS)) ? r_bcd[r_idx] : 4'd0;

    always_comb begin
        unique case (r_mode)
            MODE_HEX: w_digit_ch = (w_nib < 4'd10) ? CH_ZERO + {3'd0, w_nib}
                                                   : CH_A + {3'd0, w_nib} - 7'd10;
            MODE_BIN: w_digit_ch = CH_ZERO + {6'd0, w_low16[r_idx]};
            default:  w_digit_ch = CH_ZERO + {3'd0, w_dec};
        endcase
    end

    logic       w_can_load;
    logic [4:0] w_cnt;
    logic       w_sign;
    assign w_can_load = !r_out_valid || m_axis_tready;

    // digit count and sign flag per mode, known once the digits are ready
    always_comb begin
        w_sign = 1'b0;
        unique case (r_mode)
            MODE_DEC:  w_cnt = w_sig_len;
            MODE_FIX:  w_cnt = r_flen;
            MODE_SDEC: begin
                w_cnt  = w_sig_len;
                w_sign = 1'b1;
            end
            MODE_SFIX: begin
                w_cnt  = (r_flen > 5'd1) ? r_flen - 5'd1 : 5'd0;
                w_sign = 1'b1;
            end
            MODE_HEX:  w_cnt = 5'(HEX_DIGITS);
            MODE_BIN:  w_cnt = 5'(BIN_DIGITS);
            default:   w_cnt = 5'd0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_val       = r_val;
        n_bcd       = r_bcd;
        n_bit       = r_bit;
        n_neg       = r_neg;
        n_flen      = r_flen;
        n_row       = r_row;
        n_col       = r_col;
        n_sign_pend = r_sign_pend;
        n_rem       = r_rem;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_mode = s_axis_tuser;
                    n_neg  = w_value[31];
                    // signed modes convert the magnitude
                    n_val  = ((s_axis_tuser == MODE_SDEC || s_axis_tuser == MODE_SFIX)
                              && w_value[31]) ? 32'd0 - w_value : w_value;
                    n_flen = (w_flen > 5'(FIELD_CAP)) ? 5'(FIELD_CAP) : w_flen;
                    n_row  = w_row;
                    n_col  = {1'b0, w_scol};
                    n_bcd  = '0;
                    n_bit  = 5'd0;
                    if (s_axis_tuser <= MODE_SFIX)
                        n_state = ST_CONV;
                    else if (s_axis_tuser == MODE_HEX || s_axis_tuser == MODE_BIN)
                        n_state = ST_LOAD;
                end
            end
            ST_CONV: begin
                // shift left one bit; the top bit of the top digit is never set
                n_bcd = {w_bcd_adj[DEC_DIGITS-1][2:0], w_bcd_adj[DEC_DIGITS-2:0], r_val[31]};
                n_val = {r_val[30:0], 1'b0};
                n_bit = r_bit + 5'd1;
                if (r_bit == 5'(VALUE_BITS - 1)) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_sign_pend = w_sign;
                n_rem       = w_cnt;
                n_idx       = 4'(w_cnt - 5'd1);
                n_state     = (w_sign || w_cnt != 5'd0) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (w_can_load) begin
                    n_out_valid = 1'b1;
                    n_col       = r_col + 5'd1;
                    if (r_sign_pend) begin
                        n_out_data  = {2'b00, r_col, r_row, r_neg ? CH_MINUS : CH_PLUS};
                        n_out_last  = (r_rem == 5'd0);
                        n_sign_pend = 1'b0;
                        if (r_rem == 5'd0) n_state = ST_IDLE;
                    end else begin
                        n_out_data = {2'b00, r_col, r_row, w_digit_ch};
                        n_out_last = (r_rem == 5'd1);
                        n_rem      = r_rem - 5'd1;
                        n_idx      = r_idx - 4'd1;
                        if (r_rem == 5'd1) n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_sign_pend <= 1'b0;
            r_rem       <= 5'd0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_sign_pend <= n_sign_pend;
            r_rem       <= n_rem;
        end
        r_mode     <= n_mode;
        r_val      <= n_val;
        r_bcd      <= n_bcd;
        r_bit      <= n_bit;
        r_neg      <= n_neg;
        r_flen     <= n_flen;
        r_row      <= n_row;
        r_col      <= n_col;
        r_idx      <= n_idx;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    // emitting always has something left to send
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_sign_pend || r_rem != 5'd0))
        else $error("emit state with no character left");

    // conversion ends after exactly one pass over the value bits
    a_conv_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV && r_bit == 5'(VALUE_BITS - 1)) |=> (r_state == ST_LOAD))
        else $error("conversion did not finish on the last bit");

    // never more digit characters than a field can hold
    a_rem_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_rem <= 5'(RESULT_CAP)))
        else $error("character count above cap");

    // an accepted item never starts emitting in the next cycle
    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_EMIT))
        else $error("emit without conversion or length step");

    // a held output transfer stays put while the block keeps working
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("pending output overwritten");

endmodule
